// ===== hdl/kci_pkg.sv =====
// ----------------------------------------------------------------------------
// kci_pkg
// Shared sizes, codes and types for the keyframe curve interpolator.
// ----------------------------------------------------------------------------
package kci_pkg;

  localparam int MAX_KEYS  = 64;
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = $clog2(MAX_KEYS);
  localparam int CNT_W     = $clog2(MAX_KEYS + 1);
  localparam int QUO_W     = FRAC_BITS + 1;
  localparam int MAG_W     = DATA_W + 1;
  localparam int PROD_W    = QUO_W + MAG_W;

  // request kinds
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_SET    = 2'd2;
  localparam logic [1:0] KIND_EVAL   = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  // what every cell of the key chain does this cycle
  typedef enum logic [2:0] {
    CELL_HOLD = 3'd0,
    CELL_ROT  = 3'd1,
    CELL_INS  = 3'd2,
    CELL_DEL  = 3'd3,
    CELL_SET  = 3'd4
  } cell_op_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] t;
    logic signed [DATA_W-1:0] v;
  } key_t;

  typedef struct packed {
    cell_op_t         op;
    logic [IDX_W-1:0] sel;
    key_t             load;
  } cell_cmd_t;

endpackage

// ===== hdl/kci_cell.sv =====
// ----------------------------------------------------------------------------
// kci_cell
// One slot of the key chain: holds a (time, value) key and trades it with
// its neighbors to rotate, open a gap for an insert, or close one on removal.
// ----------------------------------------------------------------------------
module kci_cell
  import kci_pkg::*;
(
  input  logic             clk,
  input  cell_cmd_t        cmd,
  input  logic [IDX_W-1:0] slot,
  input  key_t             prev_key,
  input  key_t             next_key,
  output key_t             key
);

  // slot update
  always_ff @(posedge clk) begin
    case (cmd.op)
      CELL_ROT: key <= next_key;
      CELL_INS: begin
        if (slot > cmd.sel) begin
          key <= prev_key;
        end else if (slot == cmd.sel) begin
          key <= cmd.load;
        end
      end
      CELL_DEL: begin
        if (slot >= cmd.sel) begin
          key <= next_key;
        end
      end
      CELL_SET: begin
        if (slot == cmd.sel) begin
          key <= cmd.load;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hdl/kci_div.sv =====
// ----------------------------------------------------------------------------
// kci_div
// Restoring divider for the segment fraction floor((dt << FRAC_BITS) / span),
// one quotient bit per cycle. dt <= span, so only the low QUO_W bits can be
// set and the leading steps are skipped by preloading the remainder.
// ----------------------------------------------------------------------------
module kci_div
  import kci_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] dt,
  input  logic [DATA_W-1:0] span,
  output logic              done,
  output logic [QUO_W-1:0]  quo
);

  localparam int STEP_W = $clog2(QUO_W + 1);

  logic [DATA_W-1:0] rem;
  logic              nbit;
  logic [STEP_W-1:0] steps;
  logic              active;
  logic [DATA_W:0]   trial;
  logic              qbit;

  // trial subtract
  always_comb begin
    trial = {rem, nbit};
    qbit  = (trial >= {1'b0, span});
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      steps  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        steps  <= STEP_W'(QUO_W);
      end else if (active) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {1'b0, dt[DATA_W-1:1]};
      nbit <= dt[0];
      quo  <= '0;
    end else if (active) begin
      rem  <= qbit ? DATA_W'(trial - {1'b0, span}) : trial[DATA_W-1:0];
      nbit <= 1'b0;
      quo  <= (quo << 1) | QUO_W'(qbit);
    end
  end

endmodule

// ===== hdl/keyframe_curve_interpolator.sv =====
// ----------------------------------------------------------------------------
// keyframe_curve_interpolator
// Time-ordered key table in a chain of cells with linear interpolation.
//
//   channel | signals                                   | direction
//   in      | in_valid, in_ready, kind, key_index,      | request in
//           | key_time, key_value                       |
//   out     | out_valid, out_ready, curve_value,        | result out
//           | status, key_count                         |
//
// Add and evaluate rotate the whole chain once past its head; add then
// inserts in the apply state. Remove and set go straight to the apply state.
// Evaluate then resolves, and unless clamped to an end key runs the divider
// and the multiply and round states. Rejected requests go straight to done.
// One request is in work at a time;
// a new one is taken while the last result waits on out_ready.
// Reset clears the key count and control; key storage is not cleared.
// ----------------------------------------------------------------------------
module keyframe_curve_interpolator
  import kci_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               kind,
  input  logic [5:0]               key_index,
  input  logic signed [31:0]       key_time,
  input  logic signed [31:0]       key_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [31:0]       curve_value,
  output logic [1:0]               status,
  output logic [6:0]               key_count
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_SCAN    = 8'b0000_0010,
    S_APPLY   = 8'b0000_0100,
    S_RESOLVE = 8'b0000_1000,
    S_DIV     = 8'b0001_0000,
    S_MUL     = 8'b0010_0000,
    S_FINAL   = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_t;

  localparam logic [PROD_W-1:0] HALF =
    (FRAC_BITS > 0) ? (PROD_W'(1) << (FRAC_BITS > 0 ? FRAC_BITS - 1 : 0)) : '0;

  state_t state, state_next;

  logic [1:0]               op_kind;
  logic [IDX_W-1:0]         op_idx;
  logic signed [DATA_W-1:0] op_t;
  logic signed [DATA_W-1:0] op_v;
  logic [CNT_W-1:0]         count;
  logic [IDX_W-1:0]         scan_j;
  logic [IDX_W-1:0]         ins_pos;
  key_t                     first_key, last_key, seg0, seg1;
  logic                     found;
  logic                     neg;
  logic [MAG_W-1:0]         mag;
  logic [PROD_W-1:0]        prod;
  logic [PROD_W-1:0]        rounded;
  logic signed [DATA_W-1:0] res;
  logic [1:0]               res_status;
  logic                     div_start, div_done;
  logic [QUO_W-1:0]         frac;
  logic [DATA_W-1:0]        dt, span;
  logic [CNT_W-1:0]         j_ext;

  cell_cmd_t cmd;
  key_t      cell_key [MAX_KEYS];

  // key chain
  for (genvar k = 0; k < MAX_KEYS; k++) begin : g_cell
    kci_cell u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .slot     (IDX_W'(k)),
      .prev_key (cell_key[(k + MAX_KEYS - 1) % MAX_KEYS]),
      .next_key (cell_key[(k + 1) % MAX_KEYS]),
      .key      (cell_key[k])
    );
  end

  // fraction divider
  assign dt   = DATA_W'(op_t - seg0.t);
  assign span = DATA_W'(seg1.t - seg0.t);

  kci_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .dt    (dt),
    .span  (span),
    .done  (div_done),
    .quo   (frac)
  );

  assign in_ready = (state == S_IDLE);
  assign j_ext    = CNT_W'(scan_j);
  assign rounded  = (prod + HALF) >> FRAC_BITS;

  // chain command
  always_comb begin
    cmd.op   = CELL_HOLD;
    cmd.sel  = op_idx;
    cmd.load = '{t: op_t, v: op_v};
    if (state == S_SCAN) begin
      cmd.op = CELL_ROT;
    end else if (state == S_APPLY) begin
      case (op_kind)
        KIND_ADD: begin
          cmd.op  = CELL_INS;
          cmd.sel = ins_pos;
        end
        KIND_REMOVE: cmd.op = CELL_DEL;
        KIND_SET:    cmd.op = CELL_SET;
        default:     cmd.op = CELL_HOLD;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (kind)
            KIND_ADD:  state_next = (count >= CNT_W'(MAX_KEYS)) ? S_DONE : S_SCAN;
            KIND_EVAL: state_next = (count == '0) ? S_DONE : S_SCAN;
            default:   state_next = (CNT_W'(key_index) >= count) ? S_DONE : S_APPLY;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_j == IDX_W'(MAX_KEYS - 1)) begin
          state_next = (op_kind == KIND_ADD) ? S_APPLY : S_RESOLVE;
        end
      end
      S_APPLY: state_next = S_DONE;
      S_RESOLVE: begin
        if (count == CNT_W'(1) || op_t <= first_key.t || op_t >= last_key.t ||
            !found || seg1.t <= seg0.t) begin
          state_next = S_DONE;
        end else begin
          state_next = S_DIV;
          div_start  = 1'b1;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_MUL;
        end
      end
      S_MUL:   state_next = S_FINAL;
      S_FINAL: state_next = S_DONE;
      S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_APPLY) begin
        if (op_kind == KIND_ADD) begin
          count <= count + 1'b1;
        end else if (op_kind == KIND_REMOVE) begin
          count <= count - 1'b1;
        end
      end
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request capture, scan and arithmetic
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op_kind    <= kind;
        op_idx     <= key_index;
        op_t       <= key_time;
        op_v       <= key_value;
        scan_j     <= '0;
        ins_pos    <= '0;
        found      <= 1'b0;
        res        <= '0;
        res_status <= ST_OK;
        case (kind)
          KIND_ADD:  if (count >= CNT_W'(MAX_KEYS)) res_status <= ST_FULL;
          KIND_EVAL: if (count == '0) res_status <= ST_EMPTY;
          default:   if (CNT_W'(key_index) >= count) res_status <= ST_RANGE;
        endcase
      end
      S_SCAN: begin
        scan_j <= scan_j + 1'b1;
        // insert point: after the last key not later than the new time
        if (j_ext < count && cell_key[0].t <= op_t) begin
          ins_pos <= scan_j + 1'b1;
        end
        if (scan_j == '0) begin
          first_key <= cell_key[0];
        end
        if (j_ext + 1'b1 == count) begin
          last_key <= cell_key[0];
        end
        // first bracketing segment
        if (!found && j_ext + 1'b1 < count &&
            op_t >= cell_key[0].t && op_t <= cell_key[1].t) begin
          found <= 1'b1;
          seg0  <= cell_key[0];
          seg1  <= cell_key[1];
        end
      end
      S_RESOLVE: begin
        if (count == CNT_W'(1) || op_t <= first_key.t) begin
          res <= first_key.v;
        end else if (op_t >= last_key.t || !found) begin
          res <= last_key.v;
        end else begin
          res <= seg0.v;
        end
        neg <= (seg1.v < seg0.v);
        mag <= (seg1.v < seg0.v) ? MAG_W'({seg0.v[DATA_W-1], seg0.v} -
                                          {seg1.v[DATA_W-1], seg1.v})
                                 : MAG_W'({seg1.v[DATA_W-1], seg1.v} -
                                          {seg0.v[DATA_W-1], seg0.v});
      end
      S_MUL: prod <= PROD_W'(frac * mag);
      S_FINAL: begin
        res <= neg ? seg0.v - rounded[DATA_W-1:0] : seg0.v + rounded[DATA_W-1:0];
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      curve_value <= res;
      status      <= res_status;
      key_count   <= 7'(count);
    end
  end

endmodule
